FILE: src/assert_macros.svh
// ---------------------------------------------------------------------------
// assert_macros.svh
// Concurrent assertion helpers shared by the checker files.
// ---------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked assertion, disabled while reset is asserted (active low).
`define XBC_ASSERT(lbl, clk, rst_n, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// Clocked assertion that also holds through reset.
`define XBC_ASSERT_ALWAYS(lbl, clk, prop, msg) \
  lbl: assert property (@(posedge clk) (prop)) else $error(msg);

`endif

FILE: src/xbc_pkg.sv
// ---------------------------------------------------------------------------
// xbc_pkg
// Shared types, constants and the round mixing function of the XTEA block.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

package xbc_pkg;

  localparam int WORD_W     = 32;
  localparam int ROUND_W    = 8;
  localparam int KEY_WORDS  = 4;
  localparam int KEY_SEL_W  = 2;
  localparam int CFG_ADDR_W = 3;
  localparam int KEY_SHIFT  = 11;

  typedef logic [WORD_W-1:0]   word_t;
  typedef logic [ROUND_W-1:0]  round_t;
  typedef word_t [KEY_WORDS-1:0] key_set_t;

  localparam word_t  DELTA          = 32'h9E37_79B9;
  localparam round_t DEFAULT_ROUNDS = 8'd32;

  localparam logic [CFG_ADDR_W-1:0] REG_KEY0   = 3'd0;
  localparam logic [CFG_ADDR_W-1:0] REG_KEY1   = 3'd1;
  localparam logic [CFG_ADDR_W-1:0] REG_KEY2   = 3'd2;
  localparam logic [CFG_ADDR_W-1:0] REG_KEY3   = 3'd3;
  localparam logic [CFG_ADDR_W-1:0] REG_ROUNDS = 3'd4;

  // control of one half-round cell
  typedef struct packed {
    logic load;
    logic en;
    logic sub;
  } cell_ctl_t;

  function automatic word_t mix(input word_t x);
    mix = ((x << 4) ^ (x >> 5)) + x;
  endfunction

endpackage

FILE: src/xtea_block_cipher_top.sv
// ---------------------------------------------------------------------------
// xtea_block_cipher_top
// XTEA 64-bit block cipher with 128-bit key and configurable round count.
// ---------------------------------------------------------------------------
// One block is processed at a time by two word cells in a ring, each cell
// updating its word from its neighbor's in alternating phases, so a round
// takes one phase of each cell. A block runs N rounds from accept to result
// (N from the round register, 0 meaning 32, the default), in the half-round
// cell ring. The result sits in an output register; a new block is taken
// once the previous one has moved into it.
`timescale 1ns / 1ps

module xtea_block_cipher_top
  import xbc_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  cfg_wr_en,
  input  logic [CFG_ADDR_W-1:0] cfg_addr,
  input  word_t                 cfg_wdata,
  input  logic                  in_valid,
  output logic                  in_ready,
  input  logic                  in_op,
  input  word_t                 in_half_first,
  input  word_t                 in_half_second,
  output logic                  out_valid,
  input  logic                  out_ready,
  output word_t                 out_result_first,
  output word_t                 out_result_second
);

  key_set_t  key_words_r;
  round_t    round_cnt_r;
  cell_ctl_t ctl_a;
  cell_ctl_t ctl_b;
  word_t     sum;
  word_t     key;
  word_t     word_a;
  word_t     word_b;
  logic      out_load;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      key_words_r <= '0;
      round_cnt_r <= DEFAULT_ROUNDS;
    end else if (cfg_wr_en) begin
      case (cfg_addr)
        REG_KEY0:   key_words_r[0] <= cfg_wdata;
        REG_KEY1:   key_words_r[1] <= cfg_wdata;
        REG_KEY2:   key_words_r[2] <= cfg_wdata;
        REG_KEY3:   key_words_r[3] <= cfg_wdata;
        REG_ROUNDS: round_cnt_r    <= cfg_wdata[ROUND_W-1:0];
        default: ;
      endcase
    end
  end

  xbc_ctrl u_ctrl (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_valid),
    .in_op      (in_op),
    .in_ready   (in_ready),
    .out_ready  (out_ready),
    .out_valid_r(out_valid),
    .out_load   (out_load),
    .key_words  (key_words_r),
    .round_cnt  (round_cnt_r),
    .ctl_a      (ctl_a),
    .ctl_b      (ctl_b),
    .sum_r      (sum),
    .key        (key)
  );

  xbc_cell u_cell_a (
    .clk      (clk),
    .ctl      (ctl_a),
    .load_word(in_half_first),
    .nbr_word (word_b),
    .sum      (sum),
    .key      (key),
    .word_r   (word_a)
  );

  xbc_cell u_cell_b (
    .clk      (clk),
    .ctl      (ctl_b),
    .load_word(in_half_second),
    .nbr_word (word_a),
    .sum      (sum),
    .key      (key),
    .word_r   (word_b)
  );

  always_ff @(posedge clk) begin
    if (out_load) begin
      out_result_first  <= word_a;
      out_result_second <= word_b;
    end
  end

endmodule

FILE: src/xbc_cell.sv
// ---------------------------------------------------------------------------
// xbc_cell
// Half-round cell: holds one block word and updates it from its neighbor.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

module xbc_cell
  import xbc_pkg::*;
(
  input  logic      clk,
  input  cell_ctl_t ctl,
  input  word_t     load_word,
  input  word_t     nbr_word,
  input  word_t     sum,
  input  word_t     key,
  output word_t     word_r
);

  word_t f;
  word_t word_nxt;

  always_comb begin
    f        = mix(nbr_word) ^ (sum + key);
    word_nxt = ctl.sub ? (word_r - f) : (word_r + f);
  end

  always_ff @(posedge clk) begin
    if (ctl.load) begin
      word_r <= load_word;
    end else if (ctl.en) begin
      word_r <= word_nxt;
    end
  end

endmodule

FILE: src/xbc_ctrl.sv
// ---------------------------------------------------------------------------
// xbc_ctrl
// Round sequencer: sum, round counter, phase and cell enables.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

module xbc_ctrl
  import xbc_pkg::*;
(
  input  logic      clk,
  input  logic      rst_n,
  input  logic      in_valid,
  input  logic      in_op,
  output logic      in_ready,
  input  logic      out_ready,
  output logic      out_valid_r,
  output logic      out_load,
  input  key_set_t  key_words,
  input  round_t    round_cnt,
  output cell_ctl_t ctl_a,
  output cell_ctl_t ctl_b,
  output word_t     sum_r,
  output word_t     key
);

  typedef enum logic [1:0] {ST_IDLE, ST_RUN, ST_DONE} state_t;

  state_t                 state_r;
  round_t                 rnd_r;
  logic                   phase_r;
  logic                   dec_r;
  round_t                 rounds;
  word_t                  sum_init;
  logic                   act_b;
  logic                   run;
  logic                   accept;
  logic [KEY_SEL_W-1:0]   key_sel;

  always_comb begin
    rounds   = (round_cnt == '0) ? DEFAULT_ROUNDS : round_cnt;
    sum_init = DELTA * {{(WORD_W-ROUND_W){1'b0}}, rounds};
    act_b    = phase_r ^ dec_r;
    run      = (state_r == ST_RUN);
    in_ready = (state_r == ST_IDLE);
    accept   = in_valid && in_ready;
    key_sel  = act_b ? sum_r[KEY_SHIFT +: KEY_SEL_W] : sum_r[KEY_SEL_W-1:0];
    key      = key_words[key_sel];
    out_load = (state_r == ST_DONE) && (!out_valid_r || out_ready);
    ctl_a.load = accept;
    ctl_a.en   = run && !act_b;
    ctl_a.sub  = dec_r;
    ctl_b.load = accept;
    ctl_b.en   = run && act_b;
    ctl_b.sub  = dec_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      out_valid_r <= 1'b0;
      phase_r     <= 1'b0;
    end else begin
      if (out_valid_r && out_ready) begin
        out_valid_r <= 1'b0;
      end
      if (out_load) begin
        out_valid_r <= 1'b1;
      end
      case (state_r)
        ST_IDLE: begin
          if (in_valid) begin
            dec_r   <= in_op;
            sum_r   <= in_op ? sum_init : '0;
            rnd_r   <= rounds;
            phase_r <= 1'b0;
            state_r <= ST_RUN;
          end
        end
        ST_RUN: begin
          phase_r <= !phase_r;
          if (!phase_r) begin
            sum_r <= dec_r ? (sum_r - DELTA) : (sum_r + DELTA);
          end else begin
            rnd_r <= rnd_r - 1'b1;
            if (rnd_r == round_t'(1)) begin
              state_r <= ST_DONE;
            end
          end
        end
        ST_DONE: begin
          if (out_load) begin
            state_r <= ST_IDLE;
          end
        end
        default: begin
          state_r <= ST_IDLE;
        end
      endcase
    end
  end

endmodule

FILE: src/xbc_checker.sv
// ---------------------------------------------------------------------------
// xbc_checker
// Port-level checks on the XTEA block, bound to the top level.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "assert_macros.svh"

module xbc_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        in_valid,
  input logic        in_ready,
  input logic        out_valid,
  input logic        out_ready,
  input logic [31:0] out_result_first,
  input logic [31:0] out_result_second
);

  `XBC_ASSERT(a_out_hold, clk, rst_n, out_valid && !out_ready |=> out_valid, "out beat dropped")
  `XBC_ASSERT(a_out_stable, clk, rst_n, out_valid && !out_ready |=> $stable(out_result_first) && $stable(out_result_second), "out payload changed while stalled")
  `XBC_ASSERT(a_one_block, clk, rst_n, in_valid && in_ready |=> !in_ready, "second block taken while busy")
  `XBC_ASSERT_ALWAYS(a_reset_idle, clk, !rst_n |=> !out_valid, "out valid after reset")

endmodule

bind xtea_block_cipher_top xbc_checker u_xbc_checker (.*);

FILE: tb/sv/xtea_block_cipher_top_tb.sv
// ---------------------------------------------------------------------------
// xtea_block_cipher_top_tb
// Self-checking bench for the XTEA block cipher top level.
// ---------------------------------------------------------------------------
// Every input beat is run through an XTEA predictor that holds its own copy
// of the key words and the round count. Each output beat is compared with
// the oldest predicted block. A directed pass covers reset values, the
// all-zero and all-one blocks, the zero, one, 32 and 255 round counts,
// oversized register data and writes to unused indexes. Random phases follow,
// each with fresh keys and rounds, half of the blocks being chained outputs fed back
// with in_op as seen at their output beat inverted. Both handshakes idle and stall at random.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

module xtea_block_cipher_top_tb;
  import xbc_pkg::*;

  localparam int ITEM_TARGET  = 1700;
  localparam int STALL_LIMIT  = 4000;
  localparam int DRAIN_CYCLES = 2 * 255 + 4;
  localparam int BIG_ROUNDS   = 64;

  class xtea_scoreboard;
    typedef struct {
      word_t first;
      word_t second;
    } block_t;

    key_set_t key;
    round_t   rounds;
    block_t   expected_blocks[$];
    int       errors;
    int       checked;

    function new();
      key     = '0;
      rounds  = DEFAULT_ROUNDS;
      errors  = 0;
      checked = 0;
    endfunction

    function void set_reg(logic [CFG_ADDR_W-1:0] idx, word_t data);
      case (idx)
        REG_KEY0:   key[0] = data;
        REG_KEY1:   key[1] = data;
        REG_KEY2:   key[2] = data;
        REG_KEY3:   key[3] = data;
        REG_ROUNDS: rounds = data[ROUND_W-1:0];
        default: ;
      endcase
    endfunction

    function word_t spread(word_t x);
      return ((x << 4) ^ (x >> 5)) + x;
    endfunction

    function block_t cipher_block(logic decrypt, word_t a, word_t b);
      block_t res;
      word_t  sum;
      int     n;
      n = (rounds == 0) ? int'(DEFAULT_ROUNDS) : int'(rounds);
      if (!decrypt) begin
        sum = '0;
        for (int r = 0; r < n; r++) begin
          a += spread(b) ^ (sum + key[sum[1:0]]);
          sum += DELTA;
          b += spread(a) ^ (sum + key[sum[KEY_SHIFT+1:KEY_SHIFT]]);
        end
      end else begin
        sum = DELTA * word_t'(n);
        for (int r = 0; r < n; r++) begin
          b -= spread(a) ^ (sum + key[sum[KEY_SHIFT+1:KEY_SHIFT]]);
          sum -= DELTA;
          a -= spread(b) ^ (sum + key[sum[1:0]]);
        end
      end
      res.first  = a;
      res.second = b;
      return res;
    endfunction

    function void note_block(logic op, word_t a, word_t b);
      expected_blocks.push_back(cipher_block(op, a, b));
    endfunction

    function void check_block(word_t first, word_t second);
      block_t want;
      if (expected_blocks.size() == 0) begin
        $error("output beat with no block outstanding: %h %h", first, second);
        errors++;
        return;
      end
      want = expected_blocks.pop_front();
      checked++;
      if (first !== want.first) begin
        $error("result_first: expected %h, got %h", want.first, first);
        errors++;
      end
      if (second !== want.second) begin
        $error("result_second: expected %h, got %h", want.second, second);
        errors++;
      end
    endfunction

    function int pending();
      return expected_blocks.size();
    endfunction
  endclass

  logic                  clk = 1'b0;
  logic                  rst_n = 1'b0;
  logic                  cfg_wr_en = 1'b0;
  logic [CFG_ADDR_W-1:0] cfg_addr = '0;
  word_t                 cfg_wdata = '0;
  logic                  in_valid = 1'b0;
  logic                  in_ready;
  logic                  in_op = 1'b0;
  word_t                 in_half_first = '0;
  word_t                 in_half_second = '0;
  logic                  out_valid;
  logic                  out_ready = 1'b0;
  word_t                 out_result_first;
  word_t                 out_result_second;

  xtea_scoreboard sb = new();

  bit    idle_on = 1'b1;
  bit    stall_on = 1'b1;
  int    blocks_sent = 0;
  int    settings = 0;
  int    idle_cycles = 0;
  int    stall_left = 0;
  bit    have_last = 1'b0;
  logic  last_op = 1'b0;
  word_t last_first = '0;
  word_t last_second = '0;

  xtea_block_cipher_top dut (
    .clk               (clk),
    .rst_n             (rst_n),
    .cfg_wr_en         (cfg_wr_en),
    .cfg_addr          (cfg_addr),
    .cfg_wdata         (cfg_wdata),
    .in_valid          (in_valid),
    .in_ready          (in_ready),
    .in_op             (in_op),
    .in_half_first     (in_half_first),
    .in_half_second    (in_half_second),
    .out_valid         (out_valid),
    .out_ready         (out_ready),
    .out_result_first  (out_result_first),
    .out_result_second (out_result_second)
  );

  initial begin
    forever #6 clk = ~clk;
  end

  // beat monitor
  always @(posedge clk) begin
    if (rst_n) begin
      if (in_valid && in_ready) sb.note_block(in_op, in_half_first, in_half_second);
      if (out_valid && out_ready) begin
        sb.check_block(out_result_first, out_result_second);
        last_op     <= in_op;
        last_first  <= out_result_first;
        last_second <= out_result_second;
        have_last   <= 1'b1;
      end
    end
  end

  always @(posedge clk) begin : ready_gen
    int unsigned pause;
    if (!rst_n) begin
      out_ready  <= 1'b0;
      stall_left <= 0;
    end else if (out_valid && out_ready) begin
      pause = stall_on ? $urandom_range(0, 7) : 0;
      if (pause == 0) begin
        out_ready <= 1'b1;
      end else begin
        out_ready  <= 1'b0;
        stall_left <= pause;
      end
    end else if (stall_left > 0) begin
      stall_left <= stall_left - 1;
      if (stall_left == 1) out_ready <= 1'b1;
    end else begin
      out_ready <= 1'b1;
    end
  end

  always @(posedge clk) begin
    if (!rst_n || (in_valid && in_ready) || (out_valid && out_ready)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
    if (idle_cycles >= STALL_LIMIT) begin
      $display("timeout: no beat for %0d cycles", STALL_LIMIT);
      $display("CHECK FAILED");
      $finish;
    end
  end

  task automatic write_reg(logic [CFG_ADDR_W-1:0] idx, word_t data);
    cfg_wr_en <= 1'b1;
    cfg_addr  <= idx;
    cfg_wdata <= data;
    sb.set_reg(idx, data);
    @(posedge clk);
  endtask

  task automatic end_writes();
    cfg_wr_en <= 1'b0;
    settings++;
    @(posedge clk);
  endtask

  task automatic send_block(logic op, word_t a, word_t b);
    int unsigned gap;
    gap = idle_on ? $urandom_range(0, 7) : 0;
    if (gap != 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid       <= 1'b1;
    in_op          <= op;
    in_half_first  <= a;
    in_half_second <= b;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    blocks_sent++;
  endtask

  // let the monitor note the last accepted beat before checking pending blocks
  task automatic drain();
    in_valid <= 1'b0;
    @(posedge clk);
    while (sb.pending() != 0) @(posedge clk);
    @(posedge clk);
  endtask

  task automatic send_extremes();
    send_block(1'b0, '0, '0);
    send_block(1'b0, '1, '1);
    send_block(1'b1, '0, '0);
    send_block(1'b1, '1, '1);
    drain();
  endtask

  function automatic word_t pick_key_word();
    case ($urandom_range(0, 5))
      0:       return '0;
      1:       return '1;
      default: return $urandom;
    endcase
  endfunction

  initial begin : stimulus
    round_t rnd;
    int     eff_rounds;
    int     n_items;
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;

    // reset key and round count
    send_block(1'b0, '0, '0);
    send_block(1'b1, '1, '1);
    drain();

    // all-one key, zero round count selects the default
    write_reg(REG_KEY0, '1);
    write_reg(REG_KEY1, '1);
    write_reg(REG_KEY2, '1);
    write_reg(REG_KEY3, '1);
    write_reg(REG_ROUNDS, 32'hFFFF_FF00);
    end_writes();
    send_extremes();

    // single round, high data bits dropped
    write_reg(REG_ROUNDS, 32'h0000_0101);
    end_writes();
    send_extremes();

    // 255 rounds, sum wraps
    write_reg(REG_ROUNDS, 32'hABCD_12FF);
    end_writes();
    send_extremes();

    // unused indexes must not disturb the key
    write_reg(REG_KEY0, 32'h5555_5555);
    write_reg(REG_KEY1, 32'hAAAA_AAAA);
    write_reg(REG_KEY2, 32'h0F0F_F0F0);
    write_reg(REG_KEY3, 32'h8000_0001);
    write_reg(REG_ROUNDS, 32'd32);
    for (int i = REG_ROUNDS + 1; i < (1 << CFG_ADDR_W); i++) begin
      write_reg(i[CFG_ADDR_W-1:0], $urandom);
    end
    end_writes();
    send_block(1'b0, 32'h5555_5555, 32'hAAAA_AAAA);
    send_block(1'b1, 32'hAAAA_AAAA, 32'h5555_5555);
    send_block(1'b0, 32'h0000_0001, 32'h8000_0000);
    send_block(1'b1, 32'h8000_0000, 32'h0000_0001);
    drain();

    while (blocks_sent < ITEM_TARGET) begin
      write_reg(REG_KEY0, pick_key_word());
      write_reg(REG_KEY1, pick_key_word());
      write_reg(REG_KEY2, pick_key_word());
      write_reg(REG_KEY3, pick_key_word());
      case (settings % 8)
        0:       rnd = 8'd0;
        1:       rnd = 8'd255;
        2:       rnd = 8'd1;
        default: rnd = ($urandom_range(0, 4) == 0) ? round_t'($urandom_range(BIG_ROUNDS + 1, 255))
                                                   : round_t'($urandom_range(1, BIG_ROUNDS));
      endcase
      write_reg(REG_ROUNDS, ($urandom & 32'hFFFF_FF00) | word_t'(rnd));
      end_writes();
      eff_rounds = (rnd == 0) ? int'(DEFAULT_ROUNDS) : int'(rnd);
      idle_on    = ($urandom_range(0, 3) != 0);
      stall_on   = ($urandom_range(0, 3) != 0);
      have_last  = 1'b0;
      n_items    = (eff_rounds > BIG_ROUNDS) ? 20 : 150;
      repeat (n_items) begin
        if (have_last && $urandom_range(0, 1)) begin
          send_block(~last_op, last_first, last_second);
        end else begin
          send_block(1'($urandom_range(0, 1)), $urandom, $urandom);
        end
      end
      drain();
    end

    repeat (DRAIN_CYCLES) @(posedge clk);
    $display("%0d blocks checked under %0d key and round settings", sb.checked, settings);
    $display("round counts: zero (default), 1, 255 and random; chained encrypt/decrypt");
    if (sb.errors == 0 && sb.pending() == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule
